// ----- rtl/core/dual_tint_blend_color_mixer_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Dual tint blend color mixer assertion macros
// Shared property shorthands for the mixer checkers.
// ----------------------------------------------------------------------------
`ifndef DUAL_TINT_BLEND_COLOR_MIXER_UNIT_MACROS_SVH
`define DUAL_TINT_BLEND_COLOR_MIXER_UNIT_MACROS_SVH

// ante holds, cons holds after the delay given by dly
`define DTBM_ASSERT_DLY(lbl, clk, rstn, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##dly (cons)) \
    else $error("mixer assertion failed");

// ante holds, cons holds in the same cycle
`define DTBM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mixer assertion failed");

`endif

// ----- rtl/core/dtbm_pkg.sv -----
// ----------------------------------------------------------------------------
// Dual tint blend color mixer package
// Widths, constants, register indexes and shared types.
// ----------------------------------------------------------------------------
package dtbm_pkg;

  localparam int unsigned ChanW  = 5;
  localparam int unsigned KW     = 6;
  localparam int unsigned ArgW   = 8;
  localparam int unsigned ProdW  = 14;
  localparam int unsigned SW     = 9;
  localparam int unsigned WgtW   = 9;
  localparam int unsigned MixPW  = 20;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [15:0]      LightColor = 16'h3F9F;
  localparam logic [KW-1:0]    TintCoeff  = 6'd16;
  localparam logic [ChanW-1:0] ChanMax    = 5'd31;
  localparam logic [WgtW-1:0]  WeightRst  = 9'd256;

  localparam logic [CfgIdxW-1:0] RegFirstColor  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFirstTint   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegFirstCoeff  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSecondColor = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSecondTint  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegSecondCoeff = 3'd5;
  localparam logic [CfgIdxW-1:0] RegMixWeight   = 3'd6;

  // one setting, resolved for the current item
  typedef struct packed {
    logic                      tint;
    logic [KW-1:0]             k;
    logic [2:0][ArgW-1:0]      arg;   // tint factor or zero-extended target
  } dtbm_set_t;

  typedef logic signed [SW-1:0] dtbm_sval_t;

endpackage

// ----- rtl/core/dtbm_setting.sv -----
// ----------------------------------------------------------------------------
// Dual tint blend color mixer setting lane
// Two stages: per-channel multiply, then shift/add or tint scale.
// ----------------------------------------------------------------------------
module dtbm_setting import dtbm_pkg::*; (
  input  logic                   clk_i,
  input  dtbm_set_t              set_i,
  input  logic [2:0][ChanW-1:0]  chan_i,
  output dtbm_sval_t             s_o [3]
);

  logic                         tint_q;
  logic [2:0][ChanW-1:0]        chan_q;
  logic signed [ProdW-1:0]      prod_d [3];
  logic signed [ProdW-1:0]      prod_q [3];
  dtbm_sval_t                   s_d [3];
  dtbm_sval_t                   s_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [KW-1:0]  diff;
      logic signed [KW:0]    ks;
      logic [12:0]           tp;
      diff = signed'({1'b0, set_i.arg[i][ChanW-1:0]}) - signed'({1'b0, chan_i[i]});
      ks   = signed'({1'b0, set_i.k});
      tp   = 13'(set_i.arg[i]) * 13'(chan_i[i]);
      if (set_i.tint) begin
        prod_d[i] = signed'({1'b0, tp});
      end else begin
        prod_d[i] = ProdW'(diff * ks);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tint_q <= set_i.tint;
    chan_q <= chan_i;
    for (int i = 0; i < 3; i++) begin
      prod_q[i] <= prod_d[i];
    end
  end

  // tint product stays below 2^13, so bits 12:8 never exceed ChanMax
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [ProdW-6:0] sh;
      sh = (ProdW-5)'(prod_q[i] >>> 5);
      if (tint_q) begin
        s_d[i] = SW'({1'b0, prod_q[i][12:8]});
      end else begin
        s_d[i] = SW'(signed'({1'b0, chan_q[i]})) + SW'(sh);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      s_q[i] <= s_d[i];
    end
  end

  assign s_o = s_q;

endmodule

// ----- rtl/core/dtbm_mix.sv -----
// ----------------------------------------------------------------------------
// Dual tint blend color mixer final mix
// Weighted mix of both setting results, clamp and pack, or source bypass; output register.
// ----------------------------------------------------------------------------
module dtbm_mix import dtbm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic             bypass_i,
  input  logic [15:0]      src_i,
  input  logic [WgtW-1:0]  weight_i,
  input  dtbm_sval_t       s0_i [3],
  input  dtbm_sval_t       s1_i [3],
  output logic             done_o,
  output logic [15:0]      color_o
);

  logic                     valid_q;
  logic                     bypass_q;
  logic [15:0]              src_q;
  logic signed [MixPW-1:0]  prod_d [3];
  logic signed [MixPW-1:0]  prod_q [3];
  dtbm_sval_t               s1_q [3];
  logic                     done_q;
  logic [15:0]              color_d;
  logic [15:0]              color_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [SW:0]   diff;
      logic signed [WgtW:0] ws;
      diff = (SW+1)'(s0_i[i]) - (SW+1)'(s1_i[i]);
      ws   = signed'({1'b0, weight_i});
      prod_d[i] = MixPW'(diff * ws);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= valid_i;
      done_q  <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bypass_q <= bypass_i;
    src_q    <= src_i;
    for (int i = 0; i < 3; i++) begin
      prod_q[i] <= prod_d[i];
      s1_q[i]   <= s1_i[i];
    end
  end

  always_comb begin
    color_d = '0;
    for (int i = 0; i < 3; i++) begin
      logic signed [MixPW-9:0] sh;
      logic signed [MixPW-8:0] v;
      sh = (MixPW-8)'(prod_q[i] >>> 8);
      v  = (MixPW-7)'(s1_q[i]) + (MixPW-7)'(sh);
      if (v < 0) begin
        color_d[5*i +: 5] = '0;
      end else if (v > signed'((MixPW-7)'(ChanMax))) begin
        color_d[5*i +: 5] = ChanMax;
      end else begin
        color_d[5*i +: 5] = v[ChanW-1:0];
      end
    end
    if (bypass_q) begin
      color_d = src_q;
    end
  end

  always_ff @(posedge clk_i) begin
    color_q <= color_d;
  end

  assign done_o  = done_q;
  assign color_o = color_q;

endmodule

// ----- rtl/core/dual_tint_blend_color_mixer_unit.sv -----
// ----------------------------------------------------------------------------
// Dual tint blend color mixer unit
// Applies two blend/tint settings to an RGB555 palette entry and mixes them.
// ----------------------------------------------------------------------------
// One item is taken in every cycle and its result shows on mixed_color_o with
// done_o once it has passed the five-stage pipeline, for exactly one cycle. The
// pipeline (decode, multiply, shift/add, mix multiply, clamp) never stalls, so
// busy_o stays low and results cannot be held off. Register writes are taken
// in every cycle; change registers only while no item is in flight.
module dual_tint_blend_color_mixer_unit import dtbm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [15:0]          source_color_i,
  input  logic [15:0]          palette_base_color_i,
  input  logic                 is_entry_zero_i,
  output logic                 done_o,
  output logic [15:0]          mixed_color_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  logic [23:0]       first_color_q, second_color_q;
  logic              first_tint_q, second_tint_q;
  logic [4:0]        first_coeff_q, second_coeff_q;
  logic [WgtW-1:0]   weight_q;

  logic              accept;
  logic              special;
  logic [15:0]       target;
  dtbm_set_t         set0_d, set1_d, set0_q, set1_q;
  logic [2:0][ChanW-1:0] chan_q;

  logic              valid_a_q, valid_b_q, valid_c_q;
  logic              bypass_a_q, bypass_b_q, bypass_c_q;
  logic [15:0]       src_a_q, src_b_q, src_c_q;

  dtbm_sval_t        s0 [3];
  dtbm_sval_t        s1 [3];

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;
  assign accept      = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_color_q  <= '0;
      first_tint_q   <= 1'b0;
      first_coeff_q  <= '0;
      second_color_q <= '0;
      second_tint_q  <= 1'b0;
      second_coeff_q <= '0;
      weight_q       <= WeightRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegFirstColor:  first_color_q  <= cfg_data_i[23:0];
        RegFirstTint:   first_tint_q   <= cfg_data_i[0];
        RegFirstCoeff:  first_coeff_q  <= cfg_data_i[4:0];
        RegSecondColor: second_color_q <= cfg_data_i[23:0];
        RegSecondTint:  second_tint_q  <= cfg_data_i[0];
        RegSecondCoeff: second_coeff_q <= cfg_data_i[4:0];
        RegMixWeight:   weight_q       <= cfg_data_i[WgtW-1:0];
        default: ;
      endcase
    end
  end

  // decode: special entries blend toward entry 0 or the light color
  assign special = source_color_i[15];
  assign target  = palette_base_color_i[15] ? palette_base_color_i : LightColor;

  always_comb begin
    set0_d.tint = first_tint_q && !special;
    set1_d.tint = second_tint_q && !special;
    set0_d.k    = first_tint_q ? TintCoeff : {first_coeff_q, 1'b0};
    set1_d.k    = second_tint_q ? TintCoeff : {second_coeff_q, 1'b0};
    for (int i = 0; i < 3; i++) begin
      if (special) begin
        set0_d.arg[i] = ArgW'(target[5*i +: 5]);
        set1_d.arg[i] = ArgW'(target[5*i +: 5]);
      end else begin
        set0_d.arg[i] = first_tint_q ? first_color_q[8*i +: 8]
                                     : ArgW'(first_color_q[5*i +: 5]);
        set1_d.arg[i] = second_tint_q ? second_color_q[8*i +: 8]
                                      : ArgW'(second_color_q[5*i +: 5]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
    end else begin
      valid_a_q <= accept;
      valid_b_q <= valid_a_q;
      valid_c_q <= valid_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    set0_q     <= set0_d;
    set1_q     <= set1_d;
    for (int i = 0; i < 3; i++) begin
      chan_q[i] <= source_color_i[5*i +: 5];
    end
    bypass_a_q <= is_entry_zero_i;
    bypass_b_q <= bypass_a_q;
    bypass_c_q <= bypass_b_q;
    src_a_q    <= source_color_i;
    src_b_q    <= src_a_q;
    src_c_q    <= src_b_q;
  end

  dtbm_setting u_set0 (
    .clk_i  (clk_i),
    .set_i  (set0_q),
    .chan_i (chan_q),
    .s_o    (s0)
  );

  dtbm_setting u_set1 (
    .clk_i  (clk_i),
    .set_i  (set1_q),
    .chan_i (chan_q),
    .s_o    (s1)
  );

  dtbm_mix u_mix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_c_q),
    .bypass_i (bypass_c_q),
    .src_i    (src_c_q),
    .weight_i (weight_q),
    .s0_i     (s0),
    .s1_i     (s1),
    .done_o   (done_o),
    .color_o  (mixed_color_o)
  );

endmodule

// ----- rtl/core/dtbm_checker.sv -----
// ----------------------------------------------------------------------------
// Dual tint blend color mixer checker
// Port-level latency and result checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "dual_tint_blend_color_mixer_unit_macros.svh"

module dtbm_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_o,
  input  logic [15:0] source_color_i,
  input  logic        is_entry_zero_i,
  input  logic        done_o,
  input  logic [15:0] mixed_color_o
);

  `DTBM_ASSERT_DLY(a_item_done, clk_i, rst_ni, start_i && !busy_o, 5, done_o)
  `DTBM_ASSERT_IMP(a_done_has_item, clk_i, rst_ni, done_o, $past(start_i && !busy_o, 5))
  `DTBM_ASSERT_DLY(a_entry_zero_copy, clk_i, rst_ni, start_i && !busy_o && is_entry_zero_i, 5, mixed_color_o == $past(source_color_i, 5))
  `DTBM_ASSERT_DLY(a_bit15_clear, clk_i, rst_ni, start_i && !busy_o && !is_entry_zero_i, 5, !mixed_color_o[15])

endmodule

bind dual_tint_blend_color_mixer_unit dtbm_checker u_dtbm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .source_color_i  (source_color_i),
  .is_entry_zero_i (is_entry_zero_i),
  .done_o          (done_o),
  .mixed_color_o   (mixed_color_o)
);
